// File: sv/charge_session_meter_top_assert.svh
// assertion macros for the charge session meter
// used by charge_session_meter_top, needs clk and arst_n in scope
`ifndef CHARGE_SESSION_METER_TOP_ASSERT_SVH
`define CHARGE_SESSION_METER_TOP_ASSERT_SVH

// same-cycle implication
`define CSM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/csm_pkg.sv
// shared constants and types for the charge session meter
// no dependencies
package csm_pkg;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_RUN   = 2'd1;
	localparam logic [1:0] PH_PAUSE = 2'd2;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_PUSH  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic CFG_DEBOUNCE = 1'b0;
	localparam logic CFG_HPERIOD  = 1'b1;

	localparam logic [31:0] DEBOUNCE_RST = 32'd3000;
	localparam logic [31:0] HPERIOD_RST  = 32'd1000;
	localparam int HIST_DEPTH_DEF = 64;

	localparam logic [2:0] PK_TOTAL_MW = 3'd0;
	localparam logic [2:0] PK_TOTAL_MA = 3'd1;
	localparam logic [2:0] PK_VOUT     = 3'd2;
	localparam logic [2:0] PK_C_MW     = 3'd3;
	localparam logic [2:0] PK_A_MW     = 3'd4;

	typedef struct packed {
		logic halve;
		logic wr;
	} hist_cmd_t;

endpackage

// File: sv/csm_alu.sv
// shared 64-bit add/subtract unit of the charge session meter
// no dependencies
module csm_alu (
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic        sub,
	output logic [64:0] sum
);
	logic [63:0] b_eff;

	assign b_eff = sub ? ~b : b;
	assign sum = {1'b0, a} + {1'b0, b_eff} + {64'd0, sub};

endmodule

// File: sv/csm_hist.sv
// two history stores with the halving walk
// depends on csm_pkg
module csm_hist #(
	parameter int DEPTH = csm_pkg::HIST_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  csm_pkg::hist_cmd_t       cmd,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [16:0]              wd_c,
	input  logic [16:0]              wd_a,
	output logic                     busy
);
	import csm_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int HALF = DEPTH / 2;

	logic [16:0] mem_c [DEPTH];
	logic [16:0] mem_a [DEPTH];

	logic          walk_q;
	logic [AW-1:0] j_q;
	logic          rd_s1;
	logic [AW-1:0] waddr_s1;
	logic [16:0]   c0_s1, c1_s1, a0_s1, a1_s1;
	logic [AW:0]   pair0, pair1;
	logic [17:0]   sum_c, sum_a;

	assign pair0 = {j_q, 1'b0};
	assign pair1 = pair0 + {{AW{1'b0}}, 1'b1};
	assign sum_c = {1'b0, c0_s1} + {1'b0, c1_s1};
	assign sum_a = {1'b0, a0_s1} + {1'b0, a1_s1};
	assign busy = walk_q | rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= 1'b0;
			j_q <= '0;
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= walk_q;
			if (cmd.halve) begin
				walk_q <= 1'b1;
				j_q <= '0;
			end else if (walk_q) begin
				j_q <= j_q + {{(AW-1){1'b0}}, 1'b1};
				if (j_q == AW'(HALF - 1))
					walk_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= j_q;
		c0_s1 <= mem_c[pair0[AW-1:0]];
		c1_s1 <= mem_c[pair1[AW-1:0]];
		a0_s1 <= mem_a[pair0[AW-1:0]];
		a1_s1 <= mem_a[pair1[AW-1:0]];
		if (cmd.wr) begin
			mem_c[wr_addr] <= wd_c;
			mem_a[wr_addr] <= wd_a;
		end else if (rd_s1) begin
			mem_c[waddr_s1] <= sum_c[17:1];
			mem_a[waddr_s1] <= sum_a[17:1];
		end
	end

endmodule

// File: sv/charge_session_meter_top.sv
// charge session meter top level: sequencer, session state and ports
// depends on csm_pkg, csm_alu, csm_hist and charge_session_meter_top_assert.svh
// A clear, an unknown action, a link-lost tick or a tick without sample goes
// straight to the result; a load tick that starts or resumes a session runs
// the peak compares first; a running tick also bills time or checks the
// debounce, all add, subtract and compare steps going through the single
// 64-bit add/subtract unit one at a time. A history push into a full store
// walks half the store once before its write. Input stall is high from a transfer until its result has been taken.
`include "charge_session_meter_top_assert.svh"
module charge_session_meter_top #(
	parameter int HIST_DEPTH = csm_pkg::HIST_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] now_ms,
	input  logic        link_lost,
	input  logic        sample_valid,
	input  logic        load_present,
	input  logic [17:0] power_total_mw,
	input  logic [16:0] power_c_mw,
	input  logic [16:0] power_a_mw,
	input  logic [13:0] current_c_ma,
	input  logic [13:0] current_a_ma,
	input  logic [14:0] vout_mv,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  phase_now,
	output logic [63:0] energy_mw_ms,
	output logic [31:0] charged_ms_total,
	output logic [17:0] peak_total_mw,
	output logic [14:0] peak_total_ma,
	output logic [14:0] peak_vout,
	output logic [16:0] peak_c_mw,
	output logic [13:0] c_ma_at_peak,
	output logic [16:0] peak_a_mw,
	output logic [13:0] a_ma_at_peak,
	output logic [$clog2(HIST_DEPTH+1)-1:0] hist_entries,
	output logic [31:0] hist_period,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import csm_pkg::*;

	localparam int AW = $clog2(HIST_DEPTH);
	localparam int CW = $clog2(HIST_DEPTH + 1);
	localparam int HALF = HIST_DEPTH / 2;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_ACC    = 4'd1;
	localparam logic [3:0] S_MUL    = 4'd2;
	localparam logic [3:0] S_EADD   = 4'd3;
	localparam logic [3:0] S_CADD   = 4'd4;
	localparam logic [3:0] S_GONE   = 4'd5;
	localparam logic [3:0] S_DEB    = 4'd6;
	localparam logic [3:0] S_DEB2   = 4'd7;
	localparam logic [3:0] S_PEAK   = 4'd8;
	localparam logic [3:0] S_HSTART = 4'd9;
	localparam logic [3:0] S_HWAIT  = 4'd10;
	localparam logic [3:0] S_HPUSH  = 4'd11;
	localparam logic [3:0] S_OUT    = 4'd12;

	logic [3:0]  state_q;
	logic [2:0]  pk_q;
	logic [31:0] deb_q, hinit_q;
	logic [1:0]  phase_q;
	logic [31:0] last_q, gone_q, dt_q;
	logic        have_last_q, gone_valid_q;
	logic [63:0] energy_q;
	logic [49:0] prod_q;
	logic [31:0] charged_q;
	logic [17:0] pk_tmw_q;
	logic [14:0] pk_tma_q, pk_vout_q;
	logic [16:0] pk_cmw_q, pk_amw_q;
	logic [13:0] pk_cma_q, pk_ama_q;
	logic [CW-1:0] count_q;
	logic [31:0] period_q;

	logic [31:0] now_q;
	logic        load_q;
	logic [17:0] ptot_q;
	logic [16:0] pc_q, pa_q;
	logic [13:0] ic_q, ia_q;
	logic [14:0] vout_q;

	logic [63:0] alu_a, alu_b;
	logic        alu_sub;
	logic [64:0] alu_sum;
	logic [14:0] isum;
	logic        in_xfer;
	hist_cmd_t   hcmd;
	logic        hbusy;

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer = in_valid && !in_stall;
	assign out_valid = (state_q == S_OUT);
	assign cfg_ready = 1'b1;
	assign isum = {1'b0, ic_q} + {1'b0, ia_q};

	assign phase_now = phase_q;
	assign energy_mw_ms = energy_q;
	assign charged_ms_total = charged_q;
	assign peak_total_mw = pk_tmw_q;
	assign peak_total_ma = pk_tma_q;
	assign peak_vout = pk_vout_q;
	assign peak_c_mw = pk_cmw_q;
	assign c_ma_at_peak = pk_cma_q;
	assign peak_a_mw = pk_amw_q;
	assign a_ma_at_peak = pk_ama_q;
	assign hist_entries = count_q;
	assign hist_period = period_q;

	always_comb begin
		alu_a = '0;
		alu_b = '0;
		alu_sub = 1'b1;
		case (state_q)
			S_ACC: begin
				alu_a = {32'd0, now_q};
				alu_b = {32'd0, last_q};
			end
			S_EADD: begin
				alu_a = energy_q;
				alu_b = {14'd0, prod_q};
				alu_sub = 1'b0;
			end
			S_CADD: begin
				alu_a = {32'd0, charged_q};
				alu_b = {32'd0, dt_q};
				alu_sub = 1'b0;
			end
			S_DEB: begin
				alu_a = {32'd0, now_q};
				alu_b = {32'd0, gone_q};
			end
			S_DEB2: begin
				alu_a = {32'd0, dt_q};
				alu_b = {32'd0, deb_q};
			end
			S_PEAK: begin
				case (pk_q)
					PK_TOTAL_MW: begin
						alu_a = {46'd0, pk_tmw_q};
						alu_b = {46'd0, ptot_q};
					end
					PK_TOTAL_MA: begin
						alu_a = {49'd0, pk_tma_q};
						alu_b = {49'd0, isum};
					end
					PK_VOUT: begin
						alu_a = {49'd0, pk_vout_q};
						alu_b = {49'd0, vout_q};
					end
					PK_C_MW: begin
						alu_a = {47'd0, pk_cmw_q};
						alu_b = {47'd0, pc_q};
					end
					default: begin
						alu_a = {47'd0, pk_amw_q};
						alu_b = {47'd0, pa_q};
					end
				endcase
			end
			default: ;
		endcase
	end

	csm_alu u_alu (
		.a(alu_a),
		.b(alu_b),
		.sub(alu_sub),
		.sum(alu_sum)
	);

	always_comb begin
		hcmd.halve = (state_q == S_HSTART);
		hcmd.wr = (state_q == S_HPUSH) && (count_q < CW'(HIST_DEPTH));
	end

	csm_hist #(.DEPTH(HIST_DEPTH)) u_hist (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(hcmd),
		.wr_addr(count_q[AW-1:0]),
		.wd_c(pc_q),
		.wd_a(pa_q),
		.busy(hbusy)
	);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			now_q <= now_ms;
			load_q <= load_present;
			ptot_q <= power_total_mw;
			pc_q <= power_c_mw;
			pa_q <= power_a_mw;
			ic_q <= current_c_ma;
			ia_q <= current_a_ma;
			vout_q <= vout_mv;
		end
		if (state_q == S_MUL)
			prod_q <= ptot_q * dt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pk_q <= '0;
			deb_q <= DEBOUNCE_RST;
			hinit_q <= HPERIOD_RST;
			phase_q <= PH_IDLE;
			last_q <= '0;
			gone_q <= '0;
			dt_q <= '0;
			have_last_q <= 1'b0;
			gone_valid_q <= 1'b0;
			energy_q <= '0;
			charged_q <= '0;
			pk_tmw_q <= '0;
			pk_tma_q <= '0;
			pk_vout_q <= '0;
			pk_cmw_q <= '0;
			pk_cma_q <= '0;
			pk_amw_q <= '0;
			pk_ama_q <= '0;
			count_q <= '0;
			period_q <= HPERIOD_RST;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_DEBOUNCE)
					deb_q <= cfg_data;
				else
					hinit_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						pk_q <= PK_TOTAL_MW;
						state_q <= S_OUT;
						case (action)
							ACT_TICK: begin
								if (link_lost) begin
									if (phase_q == PH_RUN)
										phase_q <= PH_PAUSE;
									gone_q <= '0;
									gone_valid_q <= 1'b0;
								end else if (sample_valid && load_present) begin
									gone_q <= '0;
									gone_valid_q <= 1'b0;
									phase_q <= PH_RUN;
									if (phase_q == PH_IDLE) begin
										last_q <= now_ms;
										have_last_q <= 1'b1;
										energy_q <= '0;
										charged_q <= '0;
										pk_tmw_q <= '0;
										pk_tma_q <= '0;
										pk_vout_q <= '0;
										pk_cmw_q <= '0;
										pk_cma_q <= '0;
										pk_amw_q <= '0;
										pk_ama_q <= '0;
										count_q <= '0;
										period_q <= hinit_q;
										state_q <= S_PEAK;
									end else if (phase_q != PH_RUN) begin
										last_q <= now_ms;
										have_last_q <= 1'b1;
										state_q <= S_PEAK;
									end else begin
										state_q <= S_ACC;
									end
								end else if (sample_valid && phase_q == PH_RUN) begin
									state_q <= S_ACC;
								end
							end
							ACT_PUSH: begin
								if (count_q >= CW'(HIST_DEPTH)) begin
									count_q <= CW'(HALF);
									period_q <= period_q[31] ? '1 : {period_q[30:0], 1'b0};
									state_q <= S_HSTART;
								end else begin
									state_q <= S_HPUSH;
								end
							end
							ACT_CLEAR: begin
								phase_q <= PH_IDLE;
								last_q <= '0;
								gone_q <= '0;
								gone_valid_q <= 1'b0;
								have_last_q <= 1'b0;
								energy_q <= '0;
								charged_q <= '0;
								pk_tmw_q <= '0;
								pk_tma_q <= '0;
								pk_vout_q <= '0;
								pk_cmw_q <= '0;
								pk_cma_q <= '0;
								pk_amw_q <= '0;
								pk_ama_q <= '0;
								count_q <= '0;
								period_q <= hinit_q;
							end
							default: ;
						endcase
					end
				end
				S_ACC: begin
					dt_q <= alu_sum[31:0];
					last_q <= now_q;
					have_last_q <= 1'b1;
					if (have_last_q && alu_sum[64] && (alu_sum[31:0] != 32'd0))
						state_q <= S_MUL;
					else
						state_q <= load_q ? S_PEAK : S_GONE;
				end
				S_MUL: state_q <= S_EADD;
				S_EADD: begin
					energy_q <= alu_sum[64] ? '1 : alu_sum[63:0];
					state_q <= S_CADD;
				end
				S_CADD: begin
					charged_q <= alu_sum[32] ? '1 : alu_sum[31:0];
					state_q <= load_q ? S_PEAK : S_GONE;
				end
				S_GONE: begin
					if (!gone_valid_q) begin
						gone_q <= now_q;
						gone_valid_q <= 1'b1;
					end
					state_q <= S_DEB;
				end
				S_DEB: begin
					dt_q <= alu_sum[31:0];
					state_q <= S_DEB2;
				end
				S_DEB2: begin
					if (alu_sum[64])
						phase_q <= PH_PAUSE;
					state_q <= S_OUT;
				end
				S_PEAK: begin
					if (!alu_sum[64]) begin
						case (pk_q)
							PK_TOTAL_MW: pk_tmw_q <= ptot_q;
							PK_TOTAL_MA: pk_tma_q <= isum;
							PK_VOUT: pk_vout_q <= vout_q;
							PK_C_MW: begin
								pk_cmw_q <= pc_q;
								pk_cma_q <= ic_q;
							end
							default: begin
								pk_amw_q <= pa_q;
								pk_ama_q <= ia_q;
							end
						endcase
					end
					pk_q <= pk_q + 3'd1;
					if (pk_q == PK_A_MW)
						state_q <= S_OUT;
				end
				S_HSTART: state_q <= S_HWAIT;
				S_HWAIT: begin
					if (!hbusy)
						state_q <= S_HPUSH;
				end
				S_HPUSH: begin
					if (count_q < CW'(HIST_DEPTH))
						count_q <= count_q + {{(CW-1){1'b0}}, 1'b1};
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`CSM_ASSERT_NEXT(a_busy_after_xfer, in_xfer, in_stall, "input taken while item in work")
	`CSM_ASSERT_NOW(a_no_overlap, out_valid, in_stall, "input open while result pending")
	`CSM_ASSERT_NOW(a_hist_bound, 1'b1, count_q <= CW'(HIST_DEPTH), "history count beyond depth")
	`CSM_ASSERT_NOW(a_walk_idle, state_q == S_IDLE, !hbusy, "history walk running while idle")

endmodule

// File: test/csm_checker.sv
// result checker for the charge session meter: follows the session state
// from the input and config transfers and compares every output transfer
// depends on csm_pkg
module csm_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] now_ms,
	input  logic        link_lost,
	input  logic        sample_valid,
	input  logic        load_present,
	input  logic [17:0] power_total_mw,
	input  logic [16:0] power_c_mw,
	input  logic [16:0] power_a_mw,
	input  logic [13:0] current_c_ma,
	input  logic [13:0] current_a_ma,
	input  logic [14:0] vout_mv,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  phase_now,
	input  logic [63:0] energy_mw_ms,
	input  logic [31:0] charged_ms_total,
	input  logic [17:0] peak_total_mw,
	input  logic [14:0] peak_total_ma,
	input  logic [14:0] peak_vout,
	input  logic [16:0] peak_c_mw,
	input  logic [13:0] c_ma_at_peak,
	input  logic [16:0] peak_a_mw,
	input  logic [13:0] a_ma_at_peak,
	input  logic [6:0]  hist_entries,
	input  logic [31:0] hist_period,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          result_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import csm_pkg::*;

	localparam int DEPTH = 64;

	typedef struct packed {
		logic [1:0]  phase;
		logic [63:0] energy;
		logic [31:0] charged;
		logic [17:0] pk_mw;
		logic [14:0] pk_ma;
		logic [14:0] pk_v;
		logic [16:0] pk_c;
		logic [13:0] c_ma;
		logic [16:0] pk_a;
		logic [13:0] a_ma;
		logic [6:0]  entries;
		logic [31:0] period;
	} meter_view_t;

	meter_view_t readings_due[$];

	logic [31:0] debounce_ms, period_init;
	logic [1:0]  phase;
	logic [31:0] start_t, last_t, gone_t;
	logic        have_last, gone_ok;
	logic [63:0] energy;
	logic [31:0] charged;
	logic [17:0] pk_mw;
	logic [14:0] pk_ma, pk_v;
	logic [16:0] pk_c, pk_a;
	logic [13:0] c_ma, a_ma;
	logic [16:0] store_c[DEPTH], store_a[DEPTH];
	logic [6:0]  entries;
	logic [31:0] period;

	task automatic wipe_totals();
		charged = 0;
		energy = 0;
		pk_mw = 0; pk_ma = 0; pk_v = 0; pk_c = 0; pk_a = 0; c_ma = 0; a_ma = 0;
		entries = 0;
		period = period_init;
		for (int i = 0; i < DEPTH; i++) begin
			store_c[i] = 0;
			store_a[i] = 0;
		end
	endtask

	task automatic clear_session();
		phase = PH_IDLE;
		start_t = 0; last_t = 0; gone_t = 0;
		gone_ok = 0; have_last = 0;
		wipe_totals();
	endtask

	task automatic bill_time(logic [31:0] t, logic [17:0] p);
		logic [31:0] dt;
		logic [63:0] add;
		logic [64:0] esum;
		logic [32:0] csum;
		if (have_last && t > last_t) begin
			dt = t - last_t;
			add = 64'(p) * 64'(dt);
			esum = {1'b0, energy} + {1'b0, add};
			energy = esum[64] ? '1 : esum[63:0];
			csum = {1'b0, charged} + {1'b0, dt};
			charged = csum[32] ? '1 : csum[31:0];
		end
		last_t = t;
		have_last = 1;
	endtask

	task automatic push_point(logic [16:0] pc, logic [16:0] pa);
		if (entries >= DEPTH) begin
			for (int i = 0; i < DEPTH / 2; i++) begin
				store_c[i] = 17'(({1'b0, store_c[2*i]} + {1'b0, store_c[2*i+1]}) >> 1);
				store_a[i] = 17'(({1'b0, store_a[2*i]} + {1'b0, store_a[2*i+1]}) >> 1);
			end
			entries = DEPTH / 2;
			period = (period > 32'h7FFF_FFFF) ? '1 : period << 1;
		end
		if (entries < DEPTH) begin
			store_c[entries] = pc;
			store_a[entries] = pa;
			entries++;
		end
	endtask

	task automatic apply_tick();
		logic [14:0] isum;
		if (link_lost) begin
			if (phase == PH_RUN) phase = PH_PAUSE;
			gone_t = 0;
			gone_ok = 0;
		end else if (sample_valid && load_present) begin
			gone_t = 0;
			gone_ok = 0;
			if (phase == PH_IDLE) begin
				start_t = now_ms;
				last_t = now_ms;
				have_last = 1;
				wipe_totals();
			end else if (phase != PH_RUN) begin
				last_t = now_ms;
				have_last = 1;
			end else begin
				bill_time(now_ms, power_total_mw);
			end
			phase = PH_RUN;
			isum = {1'b0, current_c_ma} + {1'b0, current_a_ma};
			if (power_total_mw > pk_mw) pk_mw = power_total_mw;
			if (isum > pk_ma) pk_ma = isum;
			if (power_c_mw > pk_c) begin
				pk_c = power_c_mw;
				c_ma = current_c_ma;
			end
			if (power_a_mw > pk_a) begin
				pk_a = power_a_mw;
				a_ma = current_a_ma;
			end
			if (vout_mv > pk_v) pk_v = vout_mv;
		end else if (sample_valid && phase == PH_RUN) begin
			bill_time(now_ms, power_total_mw);
			if (!gone_ok) begin
				gone_t = now_ms;
				gone_ok = 1;
			end
			if (32'(now_ms - gone_t) >= debounce_ms) phase = PH_PAUSE;
		end
	endtask

	function automatic meter_view_t snapshot();
		return '{phase, energy, charged, pk_mw, pk_ma, pk_v, pk_c, c_ma, pk_a, a_ma,
			entries, period};
	endfunction

	task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		result_count = 0;
		debounce_ms = DEBOUNCE_RST;
		period_init = HPERIOD_RST;
		clear_session();
	end

	always @(posedge clk) begin
		meter_view_t w;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_DEBOUNCE) debounce_ms = cfg_data;
				else period_init = cfg_data;
			end
			if (in_valid && !in_stall) begin
				if (action == ACT_TICK) apply_tick();
				else if (action == ACT_PUSH) push_point(power_c_mw, power_a_mw);
				else if (action == ACT_CLEAR) clear_session();
				readings_due.push_back(snapshot());
			end
			if (out_valid && !out_stall) begin
				result_count++;
				if (readings_due.size() == 0) begin
					$error("result transfer with no expectation waiting");
					fail_count++;
				end else begin
					w = readings_due.pop_front();
					compare_field("phase_now", w.phase, phase_now);
					compare_field("energy_mw_ms", w.energy, energy_mw_ms);
					compare_field("charged_ms_total", w.charged, charged_ms_total);
					compare_field("peak_total_mw", w.pk_mw, peak_total_mw);
					compare_field("peak_total_ma", w.pk_ma, peak_total_ma);
					compare_field("peak_vout", w.pk_v, peak_vout);
					compare_field("peak_c_mw", w.pk_c, peak_c_mw);
					compare_field("c_ma_at_peak", w.c_ma, c_ma_at_peak);
					compare_field("peak_a_mw", w.pk_a, peak_a_mw);
					compare_field("a_ma_at_peak", w.a_ma, a_ma_at_peak);
					compare_field("hist_entries", w.entries, hist_entries);
					compare_field("hist_period", w.period, hist_period);
				end
			end
			pending = readings_due.size();
		end
	end
endmodule

// File: test/tb.sv
// stimulus and verdict for the charge session meter: directed and random
// session sequences, config phases, random idling and one long output hold-off
// depends on csm_pkg, csm_checker and charge_session_meter_top
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import csm_pkg::*;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_stall = 0, cfg_valid = 0, cfg_index = 0;
	logic [31:0] cfg_data = 0;
	logic [1:0]  action = 0;
	logic [31:0] now_ms = 0;
	logic link_lost = 0, sample_valid = 0, load_present = 0;
	logic [17:0] power_total_mw = 0;
	logic [16:0] power_c_mw = 0, power_a_mw = 0;
	logic [13:0] current_c_ma = 0, current_a_ma = 0;
	logic [14:0] vout_mv = 0;
	logic in_stall, out_valid, cfg_ready;
	logic [1:0]  phase_now;
	logic [63:0] energy_mw_ms;
	logic [31:0] charged_ms_total, hist_period;
	logic [17:0] peak_total_mw;
	logic [14:0] peak_total_ma, peak_vout;
	logic [16:0] peak_c_mw, peak_a_mw;
	logic [13:0] c_ma_at_peak, a_ma_at_peak;
	logic [6:0]  hist_entries;
	int fail_count, pending, result_count;
	int sent = 0;
	bit hold_done = 0;
	logic [31:0] clock_ms = 0;

	always #5 clk = ~clk;

	charge_session_meter_top uut (.*);
	csm_checker chk (.*);

	task automatic send_item(logic [1:0] act, logic [31:0] t, logic lost, logic sv,
			logic ld, logic [17:0] pt, logic [16:0] pc, logic [16:0] pa,
			logic [13:0] ic, logic [13:0] ia, logic [14:0] v);
		int idle;
		idle = $urandom_range(0, 10);
		if (idle != 0) begin
			in_valid <= 0;
			repeat (idle) @(posedge clk);
		end
		action <= act; now_ms <= t; link_lost <= lost; sample_valid <= sv;
		load_present <= ld; power_total_mw <= pt; power_c_mw <= pc; power_a_mw <= pa;
		current_c_ma <= ic; current_a_ma <= ia; vout_mv <= v;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic rand_tick(logic lost, logic sv, logic ld);
		logic [17:0] pt;
		pt = ($urandom_range(0, 7) == 0) ? 18'h3FFFF : 18'($urandom);
		clock_ms = clock_ms + (($urandom_range(0, 9) == 0) ? -$urandom_range(0, 50)
			: $urandom_range(0, 1500));
		send_item(ACT_TICK, clock_ms, lost, sv, ld, pt, 17'($urandom), 17'($urandom),
			14'($urandom), 14'($urandom), 15'($urandom));
	endtask

	task automatic write_reg(logic idx, logic [31:0] d);
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		cfg_index <= idx; cfg_data <= d; cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	always @(posedge clk) begin
		if (sent > 200 && !hold_done) begin
			hold_done <= 1;
			out_stall <= 1;
			repeat (300) @(posedge clk);
			out_stall <= 0;
		end else if (hold_done || sent < 200) begin
			out_stall <= ($urandom_range(0, 3) == 0) && (sent % 300 > 40);
			if ($urandom_range(0, 1)) repeat ($urandom_range(0, 10)) @(posedge clk);
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, every action, the special cases
		send_item(ACT_TICK, 32'd100, 0, 1, 1, '1, '1, '1, '1, '1, '1);
		send_item(ACT_TICK, 32'd100, 0, 1, 1, 18'd5, 17'd1, 17'd1, 0, 0, 0);
		send_item(ACT_TICK, 32'd50, 0, 1, 1, 18'd5, 0, 0, 0, 0, 0);
		send_item(ACT_TICK, 32'hFFFF_FFFF, 0, 1, 1, '1, 0, 0, 0, 0, 0);
		send_item(ACT_TICK, 32'd0, 0, 0, 1, '1, 0, 0, 0, 0, 0);
		send_item(ACT_TICK, 32'd0, 1, 1, 1, '1, '1, '1, '1, '1, '1);
		send_item(ACT_TICK, 32'd10, 0, 1, 1, 18'd7, 0, 0, 0, 0, 0);
		send_item(ACT_TICK, 32'd20, 0, 1, 0, 18'd7, 0, 0, 0, 0, 0);
		send_item(ACT_TICK, 32'd3020, 0, 1, 0, 18'd7, 0, 0, 0, 0, 0);
		send_item(2'd3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		for (int i = 0; i < 10; i++) send_item(ACT_PUSH, 0, 0, 0, 0, 0, '1, '1, 0, 0, 0);
		write_reg(CFG_DEBOUNCE, 32'd0);
		write_reg(CFG_HPERIOD, 32'hFFFF_FFFF);
		for (int ph = 0; ph < 5; ph++) begin
			if (ph == 1) write_reg(CFG_DEBOUNCE, 32'hFFFF_FFFF);
			if (ph == 2) begin
				write_reg(CFG_DEBOUNCE, 32'd3000);
				write_reg(CFG_HPERIOD, 32'd1);
			end
			if (ph == 3) write_reg(CFG_HPERIOD, 32'h8000_0001);
			if (ph == 4) write_reg(CFG_DEBOUNCE, $urandom_range(1, 5000));
			send_item(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
			for (int n = 0; n < 190; n++) begin
				case ((n % 95 == 94) ? 19 : $urandom_range(0, 18))
					0, 1, 2, 3, 4, 5, 6: rand_tick(0, 1, 1);
					7, 8, 9, 10: rand_tick(0, 1, 0);
					11: rand_tick(1, 1'($urandom), 1'($urandom));
					12: rand_tick(0, 0, 1'($urandom));
					13, 14, 15, 16: send_item(ACT_PUSH, $urandom, 0, 0, 0, 0,
						17'($urandom), 17'($urandom), 0, 0, 0);
					17: send_item(ACT_CLEAR, $urandom, 1'($urandom), 1'($urandom),
						1'($urandom), 18'($urandom), 0, 0, 0, 0, 0);
					18: send_item(2'd3, $urandom, 1'($urandom), 1'($urandom), 1'($urandom),
						18'($urandom), 0, 0, 0, 0, 0);
					default: for (int k = 0; k < 70; k++)
						send_item(ACT_PUSH, 0, 0, 0, 0, 0, 17'($urandom), 17'($urandom),
							0, 0, 0);
				endcase
			end
		end
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("sent %0d items over five config phases, checked %0d results",
			sent, result_count);
		if (fail_count == 0 && pending == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// File: files.f
+incdir+sv
sv/csm_pkg.sv
sv/csm_alu.sv
sv/csm_hist.sv
sv/charge_session_meter_top.sv
test/csm_checker.sv
test/tb.sv
